// ===== rtl/ordered_multimap_table_assert.svh =====
// Assertion macros used by the ordered multimap table checker.
`ifndef ORDERED_MULTIMAP_TABLE_ASSERT_SVH
`define ORDERED_MULTIMAP_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define OMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_multimap_table: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define OMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_multimap_table: next-cycle check failed");

`endif

// ===== rtl/omt_pkg.sv =====
// Types and codes for the ordered multimap table.
package omt_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 64;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] value_t;

  // One stored pair, as it sits in a memory word.
  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_FIND   = 2'd2;
  localparam kind_t KIND_LIST   = 2'd3;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_NOT_FOUND = 2'd1;
  localparam status_t STAT_FULL      = 2'd2;
  localparam status_t STAT_EMPTY     = 2'd3;

endpackage

// ===== rtl/omt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module omt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ordered_multimap_table.sv =====
// Top level of the ordered multimap table.
//
// Command channel: present in_kind, in_key and in_value with start high; the
// item is taken at a rising edge where start is high and busy is low.
// Results leave on out_* for exactly one cycle, marked by out_valid; the
// receiver takes each one at the edge that ends that cycle and cannot stall.
// out_last marks the final result of an item.
// Add: the pair is written into the table memory at once and its one result
// shows the next cycle; busy stays low, so an add may follow every cycle.
// Remove, find and list: one pass over the held pairs through the memory
// read port, one entry a cycle, with remove writing each later pair one
// place down as it streams by. Busy stays high while the item walks the
// scan state, one read per held pair, then the wait and flush states;
// an empty table goes straight to flush. The last result appears in the
// cycle after the final busy cycle.
// Reset (rst_n low at a clock edge) empties the table; memory contents are
// left as they are and are never read beyond the fill count.
module ordered_multimap_table #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  omt_pkg::kind_t       in_kind,
  input  omt_pkg::key_t        in_key,
  input  omt_pkg::value_t      in_value,
  output logic                 out_valid,
  output omt_pkg::status_t     out_status,
  output omt_pkg::key_t        out_found_key,
  output omt_pkg::value_t      out_found_value,
  output logic                 out_last
);
  import omt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  kind_t         kind_r, kind_nxt;
  key_t          key_r, key_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic          hit_r, hit_nxt;
  logic          pend_r, pend_nxt;
  entry_t        pend_ent_r, pend_ent_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  entry_t        out_ent_r, out_ent_nxt;
  logic          out_last_r, out_last_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          accept;
  logic          full;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_addr;
  logic          match;

  assign accept    = start && (state_r == ST_IDLE);
  assign full      = (count_r == CW'(DEPTH));
  assign cnt_m1    = count_r - 1'b1;
  assign last_addr = cnt_m1[AW-1:0];
  assign match     = (kind_r == KIND_LIST) || (mem_rdata.key == key_r);

  omt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequence the pass, the shift-down writes and the result register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    rd_ptr_nxt    = rd_ptr_r;
    rv_nxt        = 1'b0;
    ra_nxt        = ra_r;
    hit_nxt       = hit_r;
    pend_nxt      = pend_r;
    pend_ent_nxt  = pend_ent_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = '{key: in_key, value: in_value};
    mem_raddr     = rd_ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          key_nxt    = in_key;
          rd_ptr_nxt = '0;
          hit_nxt    = 1'b0;
          pend_nxt   = 1'b0;
          if (in_kind == KIND_ADD) begin
            // Append at the tail, answer next cycle
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_ent_nxt   = '0;
            if (full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              mem_we         = 1'b1;
              out_status_nxt = STAT_OK;
              count_nxt      = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN, ST_WAIT: begin
        // Issue the next read while entries remain
        if (state_r == ST_SCAN) begin
          rv_nxt     = 1'b1;
          ra_nxt     = rd_ptr_r;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          if (rd_ptr_r == last_addr) begin
            state_nxt = ST_WAIT;
          end
        end
        // Handle the entry that the memory returns
        if (rv_r) begin
          if (kind_r == KIND_REMOVE) begin
            if (hit_r) begin
              mem_we    = 1'b1;
              mem_waddr = ra_r - 1'b1;
              mem_wdata = mem_rdata;
            end else if (match) begin
              hit_nxt = 1'b1;
            end
          end else if (match) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
              out_ent_nxt    = pend_ent_r;
              out_last_nxt   = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_ent_nxt = mem_rdata;
          end
          if (ra_r == last_addr) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // Emit the closing result of the item
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_ent_nxt   = '0;
        if (kind_r == KIND_REMOVE) begin
          if (hit_r) begin
            out_status_nxt = STAT_OK;
            count_nxt      = count_r - 1'b1;
          end else begin
            out_status_nxt = STAT_NOT_FOUND;
          end
        end else if (pend_r) begin
          out_status_nxt = STAT_OK;
          out_ent_nxt    = pend_ent_r;
        end else if (kind_r == KIND_LIST) begin
          out_status_nxt = STAT_EMPTY;
        end else begin
          out_status_nxt = STAT_NOT_FOUND;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      hit_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      hit_r       <= hit_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    ra_r         <= ra_nxt;
    pend_ent_r   <= pend_ent_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_ent_r.key;
  assign out_found_value = out_ent_r.value;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/omt_checker.sv =====
// Port-level checks for the ordered multimap table, bound to its top level.
`include "ordered_multimap_table_assert.svh"

module omt_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input omt_pkg::kind_t   in_kind,
  input logic             out_valid,
  input omt_pkg::status_t out_status,
  input logic             out_last
);
  import omt_pkg::*;

  logic take_add;
  logic take_scan;

  assign take_add  = start && !busy && (in_kind == KIND_ADD);
  assign take_scan = start && !busy && (in_kind != KIND_ADD);

  // An add answers with a single closing result in the next cycle
  `OMT_ASSERT_NEXT(a_add_answers, take_add, out_valid && out_last)
  // Any other item holds the block busy while it walks the table
  `OMT_ASSERT_NEXT(a_scan_busy, take_scan, busy && !out_valid)
  // Only found pairs precede the closing result
  `OMT_ASSERT_SAME(a_mid_ok, out_valid && !out_last, out_status == STAT_OK)
  // A failure status always closes the item
  `OMT_ASSERT_SAME(a_fail_last, out_valid && (out_status != STAT_OK), out_last)

endmodule

bind ordered_multimap_table omt_checker u_omt_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the ordered multimap table: directed rows, then random items.
`timescale 1ns / 100ps

module testbench;
  import omt_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 202;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    status_t status;
    key_t    key;
    value_t  value;
    logic    last;
  } table_result_t;

  typedef struct {
    kind_t   kind;
    key_t    key;
    value_t  value;
    logic    pinned;
    status_t pin_status;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  // Directed rows; pinned rows carry their single result, the rest go through the predictor
  script_row_t script [SCRIPT_LEN] = '{
    '{KIND_LIST,   32'h0000_0000, 64'h0,                   1'b1, STAT_EMPTY},
    '{KIND_FIND,   32'h0000_0005, 64'h0,                   1'b1, STAT_NOT_FOUND},
    '{KIND_REMOVE, 32'h0000_0005, 64'h0,                   1'b1, STAT_NOT_FOUND},
    '{KIND_ADD,    32'h8000_0000, 64'h0,                   1'b1, STAT_OK},
    '{KIND_ADD,    32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK},
    '{KIND_ADD,    32'hFFFF_FFFF, 64'h8000_0000_0000_0001, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0000, 64'h0123_4567_89AB_CDEF, 1'b1, STAT_OK},
    '{KIND_ADD,    32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210, 1'b1, STAT_OK},
    '{KIND_FIND,   32'hFFFF_FFFF, 64'h0,                   1'b0, STAT_OK},
    '{KIND_FIND,   32'h7FFF_FFFE, 64'h0,                   1'b1, STAT_NOT_FOUND},
    '{KIND_ADD,    32'h0000_0007, 64'h5555_5555_5555_5555, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0007, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h7FFF_FFFF, 64'h0000_0000_0000_0001, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0001, 64'h0000_0000_0000_0002, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0007, 64'h0000_0000_0000_0003, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0002, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, STAT_OK},
    '{KIND_ADD,    32'hFFFF_FFFE, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0003, 64'h0000_0001_0000_0000, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0007, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0004, 64'h1111_2222_3333_4444, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0005, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, STAT_OK},
    '{KIND_ADD,    32'h0000_0009, 64'h0000_0000_0000_0009, 1'b1, STAT_FULL},
    '{KIND_LIST,   32'h0000_0000, 64'h0,                   1'b0, STAT_OK},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 64'h0,                   1'b1, STAT_OK},
    '{KIND_REMOVE, 32'h0000_0005, 64'h0,                   1'b1, STAT_OK},
    '{KIND_FIND,   32'h0000_0007, 64'h0,                   1'b0, STAT_OK},
    '{KIND_REMOVE, 32'h8000_0000, 64'h0,                   1'b1, STAT_OK},
    '{KIND_LIST,   32'h0000_0000, 64'h0,                   1'b0, STAT_OK}
  };

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  kind_t   in_kind = KIND_ADD;
  key_t    in_key = '0;
  value_t  in_value = '0;
  logic    busy;
  logic    out_valid;
  status_t out_status;
  key_t    out_found_key;
  value_t  out_found_value;
  logic    out_last;

  // Predictor state: a private copy of the table
  key_t   entry_keys [DEPTH];
  value_t entry_values [DEPTH];
  int     held = 0;

  table_result_t step_results [$];
  table_result_t pending_results [$];
  int failures = 0;
  int idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  ordered_multimap_table #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_key  (out_found_key),
    .out_found_value(out_found_value),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic table_result_t make_result(status_t status, key_t key, value_t value,
                                                logic last);
    table_result_t r;
    r.status = status;
    r.key = key;
    r.value = value;
    r.last = last;
    return r;
  endfunction

  // Append one result to the results of the current item
  task automatic append_step(input table_result_t r);
    step_results = {step_results, r};
  endtask

  // Append one result to the expectations still to be seen
  task automatic append_pending(input table_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Apply one item to the private table and collect the results it causes
  task automatic table_apply(input kind_t kind, input key_t key, input value_t value);
    int hit;
    step_results.delete();
    case (kind)
      KIND_ADD: begin
        if (held >= DEPTH) begin
          append_step(make_result(STAT_FULL, '0, '0, 1'b1));
        end else begin
          entry_keys[held] = key;
          entry_values[held] = value;
          held++;
          append_step(make_result(STAT_OK, '0, '0, 1'b1));
        end
      end
      KIND_REMOVE: begin
        hit = -1;
        for (int i = 0; i < held; i++) begin
          if (hit < 0 && entry_keys[i] == key) hit = i;
        end
        if (hit < 0) begin
          append_step(make_result(STAT_NOT_FOUND, '0, '0, 1'b1));
        end else begin
          // close the gap so table order is kept
          for (int i = hit; i + 1 < held; i++) begin
            entry_keys[i] = entry_keys[i + 1];
            entry_values[i] = entry_values[i + 1];
          end
          held--;
          append_step(make_result(STAT_OK, '0, '0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < held; i++) begin
          if (kind == KIND_LIST || entry_keys[i] == key)
            append_step(make_result(STAT_OK, entry_keys[i], entry_values[i], 1'b0));
        end
        if (step_results.size() == 0) begin
          append_step(make_result(kind == KIND_LIST ? STAT_EMPTY : STAT_NOT_FOUND,
                                  '0, '0, 1'b1));
        end else begin
          step_results[step_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one item after a random gap, hold it until taken, then record its results
  task automatic send_item(input kind_t kind, input key_t key, input value_t value,
                           input logic pinned, input status_t pin_status);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_apply(kind, key, value);
    if (pinned) begin
      append_pending(make_result(pin_status, '0, '0, 1'b1));
    end else begin
      foreach (step_results[i]) append_pending(step_results[i]);
    end
    items_sent++;
    // sender idles 16 in 100, then 71 in 100, then never
    if (items_sent < 77) idle_pct = 16;
    else if (items_sent < 154) idle_pct = 71;
    else idle_pct = 0;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d found_key %0d found_value %h last %0b",
               out_status, out_found_key, out_found_value, out_last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
        if (out_found_key !== want.key) begin
          $error("found_key: expected %0d, got %0d", want.key, out_found_key);
          failures++;
        end
        if (out_found_value !== want.value) begin
          $error("found_value: expected %h, got %h", want.value, out_found_value);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          failures++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (out_valid && pending_results.size() != 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ordered_multimap_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    kind_t  kind;
    key_t   key;
    value_t value;
    int     roll;
    logic   filling;

    idle_pct = 16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed rows
    for (int r = 0; r < SCRIPT_LEN; r++)
      send_item(script[r].kind, script[r].key, script[r].value,
                script[r].pinned, script[r].pin_status);

    // random items: alternate stretches that fill and drain the table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / 32) % 2) == 0;
      roll = $urandom_range(99);
      if (filling)
        kind = roll < 55 ? KIND_ADD : roll < 70 ? KIND_REMOVE : roll < 85 ? KIND_FIND : KIND_LIST;
      else
        kind = roll < 20 ? KIND_ADD : roll < 65 ? KIND_REMOVE : roll < 85 ? KIND_FIND : KIND_LIST;

      // draw keys mostly from a small set so duplicates and hits are common
      roll = $urandom_range(99);
      if (kind == KIND_REMOVE && held > 0 && roll < 60) begin
        key = entry_keys[$urandom_range(held - 1)];
      end else if (roll < 80) begin
        case ($urandom_range(5))
          0: key = 32'h0000_0000;
          1: key = 32'hFFFF_FFFF;
          2: key = 32'h0000_0007;
          3: key = 32'h8000_0000;
          4: key = 32'h7FFF_FFFF;
          default: key = 32'h0000_0003;
        endcase
      end else begin
        key = $urandom;
      end
      value = {$urandom, $urandom};
      send_item(kind, key, value, 1'b0, STAT_OK);
    end

    // drop start and let the last results arrive
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0)
      $display("ordered_multimap_table regression: pass");
    else
      $display("ordered_multimap_table regression: fail");
    $finish;
  end

endmodule

// ===== ordered_multimap_table.f =====
+incdir+rtl
rtl/omt_pkg.sv
rtl/omt_ram.sv
rtl/ordered_multimap_table.sv
rtl/omt_checker.sv
sim/testbench.sv
